FILE: rtl/core/dtt_pkg.sv
// shared types and constants of the dirty tile tracker
package dtt_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned COMP_W  = 8;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned COLOR_W = 32;
   localparam int unsigned ROW_OUT_W  = 6;
   localparam int unsigned MASK_OUT_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_TILES_ACROSS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TILES_DOWN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RED_SHIFT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GREEN_SHIFT  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BLUE_SHIFT   = 3'd4;

   typedef enum logic [1:0] {
      OP_MARK  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // grid size already limited to 1..max, shifts as written
   typedef struct packed {
      logic [COUNT_W-1:0] cols;
      logic [COUNT_W-1:0] rows;
      logic [SHIFT_W-1:0] red_shift;
      logic [SHIFT_W-1:0] green_shift;
      logic [SHIFT_W-1:0] blue_shift;
   } cfg_type;

endpackage

FILE: rtl/core/dtt_csr.sv
// configuration registers behind the apb-style port
module dtt_csr
   import dtt_pkg::*;
#(
   parameter int unsigned MAX_TILE_COLUMNS = 64,
   parameter int unsigned MAX_TILE_ROWS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [COUNT_W-1:0] tiles_across_ff, tiles_across_in;
   logic [COUNT_W-1:0] tiles_down_ff, tiles_down_in;
   logic [SHIFT_W-1:0] red_shift_ff, red_shift_in;
   logic [SHIFT_W-1:0] green_shift_ff, green_shift_in;
   logic [SHIFT_W-1:0] blue_shift_ff, blue_shift_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      tiles_across_in = tiles_across_ff;
      tiles_down_in   = tiles_down_ff;
      red_shift_in    = red_shift_ff;
      green_shift_in  = green_shift_ff;
      blue_shift_in   = blue_shift_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TILES_ACROSS: tiles_across_in = pwdata[COUNT_W-1:0];
            REG_TILES_DOWN:   tiles_down_in   = pwdata[COUNT_W-1:0];
            REG_RED_SHIFT:    red_shift_in    = pwdata[SHIFT_W-1:0];
            REG_GREEN_SHIFT:  green_shift_in  = pwdata[SHIFT_W-1:0];
            REG_BLUE_SHIFT:   blue_shift_in   = pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_across_ff <= 7'd64;
         tiles_down_ff   <= 7'd64;
         red_shift_ff    <= 5'd16;
         green_shift_ff  <= 5'd8;
         blue_shift_ff   <= 5'd0;
      end else begin
         tiles_across_ff <= tiles_across_in;
         tiles_down_ff   <= tiles_down_in;
         red_shift_ff    <= red_shift_in;
         green_shift_ff  <= green_shift_in;
         blue_shift_ff   <= blue_shift_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TILES_ACROSS: prdata = CSR_DATA_W'(tiles_across_ff);
         REG_TILES_DOWN:   prdata = CSR_DATA_W'(tiles_down_ff);
         REG_RED_SHIFT:    prdata = CSR_DATA_W'(red_shift_ff);
         REG_GREEN_SHIFT:  prdata = CSR_DATA_W'(green_shift_ff);
         REG_BLUE_SHIFT:   prdata = CSR_DATA_W'(blue_shift_ff);
         default:          prdata = '0;
      endcase
   end

   // zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (tiles_across_ff == '0)
         cfg.cols = 7'd1;
      else if (tiles_across_ff > COUNT_W'(MAX_TILE_COLUMNS))
         cfg.cols = COUNT_W'(MAX_TILE_COLUMNS);
      else
         cfg.cols = tiles_across_ff;
      if (tiles_down_ff == '0)
         cfg.rows = 7'd1;
      else if (tiles_down_ff > COUNT_W'(MAX_TILE_ROWS))
         cfg.rows = COUNT_W'(MAX_TILE_ROWS);
      else
         cfg.rows = tiles_down_ff;
      cfg.red_shift   = red_shift_ff;
      cfg.green_shift = green_shift_ff;
      cfg.blue_shift  = blue_shift_ff;
   end

endmodule

FILE: rtl/core/dtt_tile_mem.sv
// bitmap memory: one word per tile row holding clear and flush bits
module dtt_tile_mem
   import dtt_pkg::*;
#(
   parameter int unsigned ROWS   = 64,
   parameter int unsigned COLS   = 64,
   parameter int unsigned ROW_W  = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ROW_W-1:0]    rd_addr,
   output logic [2*COLS-1:0]   rd_data,
   input  logic                wr_en,
   input  logic [ROW_W-1:0]    wr_addr,
   input  logic [2*COLS-1:0]   wr_data
);

   logic [2*COLS-1:0] tile_mem [ROWS];
   logic [ROWS-1:0]   row_valid_ff;
   logic [2*COLS-1:0] rd_word_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         tile_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_word_ff <= tile_mem[rd_addr];
   end

   // rows never written since reset read as all zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en)
            row_valid_ff[wr_addr] <= 1'b1;
         if (rd_en)
            rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

FILE: rtl/core/dtt_ctrl.sv
// command sequencer: row walk with read-modify-write of the bitmap memory
module dtt_ctrl
   import dtt_pkg::*;
#(
   parameter int unsigned TILE_SHIFT = 5,
   parameter int unsigned COLS       = 64,
   parameter int unsigned ROW_W      = 6,
   parameter int unsigned COL_W      = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [COORD_W-1:0]    req_left_x,
   input  logic [COORD_W-1:0]    req_top_y,
   input  logic [COORD_W-1:0]    req_right_x,
   input  logic [COORD_W-1:0]    req_bottom_y,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   output logic                  rsp_valid,
   output logic [ROW_OUT_W-1:0]  rsp_tile_row,
   output logic [MASK_OUT_W-1:0] rsp_fill_mask,
   output logic [COLOR_W-1:0]    rsp_fill_color,
   output logic                  rsp_tile_dirty,
   output logic                  rsp_tile_pending_clear,
   output logic                  rsp_last,
   output logic                  mem_rd_en,
   output logic [ROW_W-1:0]      mem_rd_addr,
   input  logic [2*COLS-1:0]     mem_rd_data,
   output logic                  mem_wr_en,
   output logic [ROW_W-1:0]      mem_wr_addr,
   output logic [2*COLS-1:0]     mem_wr_data
);

   op_type req_op;
   logic   accept;
   logic   go;
   logic [COORD_W-1:0] lx_tile, rx_tile, ty_tile, by_tile;
   logic [COUNT_W-1:0] cols_m1, rows_m1;
   logic [COUNT_W-1:0] x0, x1, y0, y1;
   logic               rect_empty;
   logic               query_hit;
   logic [COLS-1:0]    rect_mask, grid_mask;
   logic [COLOR_W-1:0] color;

   op_type             op_ff, op_in;
   logic               busy_ff, busy_in;
   logic               issuing_ff, issuing_in;
   logic [ROW_W-1:0]   rd_row_ff, rd_row_in;
   logic [ROW_W-1:0]   end_row_ff, end_row_in;
   logic [COLS-1:0]    mask_ff, mask_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               hit_ff, hit_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]   s1_row_ff, s1_row_in;
   logic               s1_last_ff, s1_last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [MASK_OUT_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic                  rsp_dirty_ff, rsp_dirty_in;
   logic                  rsp_pend_ff, rsp_pend_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [COLS-1:0] row_flush, row_clear, clear_hits;

   assign req_op = op_type'(req_opcode);
   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // tile bounds of the request, clamped to the grid in use
   assign lx_tile = req_left_x >> TILE_SHIFT;
   assign rx_tile = req_right_x >> TILE_SHIFT;
   assign ty_tile = req_top_y >> TILE_SHIFT;
   assign by_tile = req_bottom_y >> TILE_SHIFT;
   assign cols_m1 = cfg.cols - 7'd1;
   assign rows_m1 = cfg.rows - 7'd1;
   assign x0 = (lx_tile > COORD_W'(cols_m1)) ? cols_m1 : lx_tile[COUNT_W-1:0];
   assign x1 = (rx_tile > COORD_W'(cols_m1)) ? cols_m1 : rx_tile[COUNT_W-1:0];
   assign y0 = (ty_tile > COORD_W'(rows_m1)) ? rows_m1 : ty_tile[COUNT_W-1:0];
   assign y1 = (by_tile > COORD_W'(rows_m1)) ? rows_m1 : by_tile[COUNT_W-1:0];
   assign rect_empty = (x0 > x1) || (y0 > y1);
   assign query_hit  = (lx_tile < COORD_W'(cfg.cols)) && (ty_tile < COORD_W'(cfg.rows));

   always_comb begin
      for (int i = 0; i < COLS; i++) begin
         rect_mask[i] = (COUNT_W'(i) >= x0) && (COUNT_W'(i) <= x1);
         grid_mask[i] = COUNT_W'(i) < cfg.cols;
      end
   end

   assign color = (COLOR_W'(req_red) << cfg.red_shift)
                | (COLOR_W'(req_green) << cfg.green_shift)
                | (COLOR_W'(req_blue) << cfg.blue_shift);

   always_comb begin
      unique case (req_op) inside
         OP_CLEAR, OP_QUERY: go = accept;
         OP_MARK:            go = accept && !rect_empty;
         default:            go = 1'b0;
      endcase
   end

   // stage 1 sees the row read in the previous cycle
   assign row_flush  = mem_rd_data[COLS-1:0];
   assign row_clear  = mem_rd_data[2*COLS-1:COLS];
   assign clear_hits = row_clear & mask_ff;

   always_comb begin
      op_in       = op_ff;
      busy_in     = busy_ff;
      issuing_in  = issuing_ff;
      rd_row_in   = rd_row_ff;
      end_row_in  = end_row_ff;
      mask_in     = mask_ff;
      color_in    = color_ff;
      hit_in      = hit_ff;
      col_in      = col_ff;
      s1_valid_in = issuing_ff;
      s1_row_in   = rd_row_ff;
      s1_last_in  = rd_row_ff == end_row_ff;

      if (go) begin
         op_in      = req_op;
         busy_in    = 1'b1;
         issuing_in = 1'b1;
         color_in   = color;
         hit_in     = query_hit;
         col_in     = lx_tile[COL_W-1:0];
         unique case (req_op)
            OP_MARK: begin
               rd_row_in  = y0[ROW_W-1:0];
               end_row_in = y1[ROW_W-1:0];
               mask_in    = rect_mask;
            end
            OP_CLEAR: begin
               rd_row_in  = '0;
               end_row_in = rows_m1[ROW_W-1:0];
               mask_in    = grid_mask;
            end
            default: begin
               rd_row_in  = ty_tile[ROW_W-1:0];
               end_row_in = ty_tile[ROW_W-1:0];
            end
         endcase
      end else if (issuing_ff) begin
         if (rd_row_ff == end_row_ff)
            issuing_in = 1'b0;
         else
            rd_row_in = rd_row_ff + ROW_W'(1);
      end

      if (s1_valid_ff && s1_last_ff)
         busy_in = 1'b0;
   end

   assign mem_rd_en   = issuing_ff;
   assign mem_rd_addr = rd_row_ff;
   assign mem_wr_addr = s1_row_ff;

   always_comb begin
      mem_wr_en    = 1'b0;
      mem_wr_data  = mem_rd_data;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_color_in = rsp_color_ff;
      rsp_dirty_in = rsp_dirty_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_valid_ff) begin
         unique case (op_ff)
            OP_MARK: begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {row_clear | mask_ff, row_flush | mask_ff};
            end
            OP_CLEAR: begin
               mem_wr_en    = 1'b1;
               mem_wr_data  = {row_clear & ~clear_hits, row_flush | clear_hits};
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_OUT_W'(s1_row_ff);
               rsp_mask_in  = MASK_OUT_W'(clear_hits);
               rsp_color_in = color_ff;
               rsp_dirty_in = 1'b0;
               rsp_pend_in  = 1'b0;
               rsp_last_in  = s1_last_ff;
            end
            OP_QUERY: begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = '0;
               rsp_mask_in  = '0;
               rsp_color_in = '0;
               rsp_dirty_in = hit_ff && row_flush[col_ff];
               rsp_pend_in  = hit_ff && row_clear[col_ff];
               rsp_last_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         issuing_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         issuing_ff   <= issuing_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      rd_row_ff    <= rd_row_in;
      end_row_ff   <= end_row_in;
      mask_ff      <= mask_in;
      color_ff     <= color_in;
      hit_ff       <= hit_in;
      col_ff       <= col_in;
      s1_row_ff    <= s1_row_in;
      s1_last_ff   <= s1_last_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_color_ff <= rsp_color_in;
      rsp_dirty_ff <= rsp_dirty_in;
      rsp_pend_ff  <= rsp_pend_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_tile_row           = rsp_row_ff;
   assign rsp_fill_mask          = rsp_mask_ff;
   assign rsp_fill_color         = rsp_color_ff;
   assign rsp_tile_dirty         = rsp_dirty_ff;
   assign rsp_tile_pending_clear = rsp_pend_ff;
   assign rsp_last               = rsp_last_ff;

endmodule

FILE: rtl/core/dirty_tile_tracker.sv
// top level of the dirty tile tracker
//
// commands enter on the req_ ports and are taken on a clock edge with start high
// and busy low. mark sets the flush and clear bits of every tile inside a pixel
// rectangle, clear emits one transfer per tile row in use with the tiles to fill
// and the packed color, query returns the two bits of one tile.
// results leave on the rsp_ ports, each valid for one cycle while rsp_valid is
// high; rsp_last flags the final transfer of a command. the receiver cannot stall.
// timing: a command walks its tile rows through the bitmap memory, one read per
// cycle, with the write-back in the following cycle. busy stays high through the
// write-back of the last row, and the next command is taken once busy is low.
// results are registered after stage 1; once they start, one follows each cycle.
// the single memory read port sets this rate. a mark whose bounds are empty and
// the unused opcode finish in the accepting cycle.
// reset clears both bitmaps at once through per-row valid bits and loads the
// register defaults. registers are written over the apb-style port; the user
// must write them only while idle, as the block itself does not enforce it.
module dirty_tile_tracker
   import dtt_pkg::*;
#(
   parameter int unsigned TILE_SHIFT       = 5,
   parameter int unsigned MAX_TILE_COLUMNS = 64,
   parameter int unsigned MAX_TILE_ROWS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [COORD_W-1:0]    req_left_x,
   input  logic [COORD_W-1:0]    req_top_y,
   input  logic [COORD_W-1:0]    req_right_x,
   input  logic [COORD_W-1:0]    req_bottom_y,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   output logic                  rsp_valid,
   output logic [ROW_OUT_W-1:0]  rsp_tile_row,
   output logic [MASK_OUT_W-1:0] rsp_fill_mask,
   output logic [COLOR_W-1:0]    rsp_fill_color,
   output logic                  rsp_tile_dirty,
   output logic                  rsp_tile_pending_clear,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int unsigned ROW_W = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
   localparam int unsigned COL_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;

   cfg_type                   cfg;
   logic                      mem_rd_en;
   logic [ROW_W-1:0]          mem_rd_addr;
   logic [2*MAX_TILE_COLUMNS-1:0] mem_rd_data;
   logic                      mem_wr_en;
   logic [ROW_W-1:0]          mem_wr_addr;
   logic [2*MAX_TILE_COLUMNS-1:0] mem_wr_data;

   dtt_csr #(
      .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
      .MAX_TILE_ROWS    (MAX_TILE_ROWS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtt_tile_mem #(
      .ROWS  (MAX_TILE_ROWS),
      .COLS  (MAX_TILE_COLUMNS),
      .ROW_W (ROW_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   dtt_ctrl #(
      .TILE_SHIFT (TILE_SHIFT),
      .COLS       (MAX_TILE_COLUMNS),
      .ROW_W      (ROW_W),
      .COL_W      (COL_W)
   ) u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .start                  (start),
      .busy                   (busy),
      .req_opcode             (req_opcode),
      .req_left_x             (req_left_x),
      .req_top_y              (req_top_y),
      .req_right_x            (req_right_x),
      .req_bottom_y           (req_bottom_y),
      .req_red                (req_red),
      .req_green              (req_green),
      .req_blue               (req_blue),
      .rsp_valid              (rsp_valid),
      .rsp_tile_row           (rsp_tile_row),
      .rsp_fill_mask          (rsp_fill_mask),
      .rsp_fill_color         (rsp_fill_color),
      .rsp_tile_dirty         (rsp_tile_dirty),
      .rsp_tile_pending_clear (rsp_tile_pending_clear),
      .rsp_last               (rsp_last),
      .mem_rd_en              (mem_rd_en),
      .mem_rd_addr            (mem_rd_addr),
      .mem_rd_data            (mem_rd_data),
      .mem_wr_en              (mem_wr_en),
      .mem_wr_addr            (mem_wr_addr),
      .mem_wr_data            (mem_wr_data)
   );

endmodule

FILE: rtl/core/dtt_checker.sv
// port-level checks of the dirty tile tracker, bound to the top level
module dtt_checker
   import dtt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [1:0]            req_opcode,
   input logic                  rsp_valid,
   input logic                  rsp_last,
   input logic                  rsp_tile_dirty,
   input logic                  rsp_tile_pending_clear,
   input logic [MASK_OUT_W-1:0] rsp_fill_mask
);

   // an accepted query always occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_QUERY) |=> busy)
      else $error("query transfer did not raise busy");

   // more clear rows to come means the block is still busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // query answers come alone with an empty mask
   a_query_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tile_dirty || rsp_tile_pending_clear)
         |-> rsp_last && (rsp_fill_mask == '0))
      else $error("query answer mixed with clear result");

   // the next command cannot produce a result right after a final one
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result directly after final transfer");

endmodule

bind dirty_tile_tracker dtt_checker u_dtt_checker (.*);
